// ===== src/mgfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mgfs_pkg - shared types and constants of the fire spread block
// Item layouts, the bits that pass between neighboring column cells,
// and sizes of the result queue.
// ----------------------------------------------------------------------------
package mgfs_pkg;

	localparam int ROW_W = 64;              // width of one grid row
	localparam int COLS_W = 7;              // width of the column count register
	localparam logic [COLS_W-1:0] COLS_RESET = 7'd64;

	localparam int QUEUE_DEPTH = 3;         // result queue entries
	localparam int QCNT_W = 2;              // holds 0..QUEUE_DEPTH
	localparam int PUSH_W = 2;              // results per input item: 0..2

	// One input item
	typedef struct packed {
		logic [ROW_W-1:0] fire_row;
		logic [ROW_W-1:0] obstacle_row;
		logic             last_row;
	} in_item_t;

	// One result item
	typedef struct packed {
		logic [ROW_W-1:0] new_fire_row;
		logic             final_row;
	} out_item_t;

	// Fire bits one column shows to its neighbors
	typedef struct packed {
		logic two;   // row above the held row
		logic prev;  // held row
		logic cur;   // arriving row, masked
	} cell_bits_t;

endpackage

// ===== src/masked_grid_fire_spread.sv =====
// ----------------------------------------------------------------------------
// masked_grid_fire_spread - one generation of fire spread, row by row
//
// Channels: in_valid/in_ready/in_data carries grid rows top first (fire
// bits, obstacle bits, last-row flag); out_valid/out_ready/out_data
// returns new rows with a final-row flag; cfg_valid/cfg_ready/cfg_data
// writes the column count, taken in any cycle (cfg_ready is always high).
// Row r-1 of the new grid leaves when row r arrives; the last row brings
// out the held row and itself, one item per cycle while the receiver
// takes them, and the row state clears. Results are registered in the
// queue before they are shown. One row per cycle is accepted while the
// result queue (three entries) has room for two results, so throughput
// is one row per cycle whenever the receiver takes one result per cycle;
// a last row adds a second result. Each column is a cell that trades its
// stored bits with its two neighbors in the same cycle. Reset clears the
// stored rows and the queue and sets the column count to 64. When the
// receiver stalls, results wait in the queue and in_ready falls once
// fewer than two entries are free.
// ----------------------------------------------------------------------------
module masked_grid_fire_spread
	import mgfs_pkg::*;
#(
	parameter int GRID_COLUMNS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [COLS_W-1:0] cfg_data
);

	logic [COLS_W-1:0]       columns_q;
	logic                    held_q;       // a row of this grid is held
	logic                    accept;
	logic                    room;
	logic [GRID_COLUMNS-1:0] res_held;
	logic [GRID_COLUMNS-1:0] res_last;
	logic [ROW_W-1:0]        row_held;
	logic [ROW_W-1:0]        row_last;
	logic [PUSH_W-1:0]       push_n;
	out_item_t               push_first;
	out_item_t               push_second;
	cell_bits_t              bits [GRID_COLUMNS];

	assign cfg_ready = 1'b1;
	assign in_ready  = room;
	assign accept    = in_valid & in_ready;

	// Column count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLS_RESET;
		end else if (cfg_valid) begin
			columns_q <= cfg_data;
		end
	end

	// Grid progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
		end else if (accept) begin
			held_q <= ~in_data.last_row;
		end
	end

	// Row of column cells
	for (genvar j = 0; j < GRID_COLUMNS; j++) begin : g_col
		cell_bits_t left_bits;
		cell_bits_t right_bits;

		if (j == 0) begin : g_left_edge
			assign left_bits = '0;
		end else begin : g_left
			assign left_bits = bits[j-1];
		end
		if (j == GRID_COLUMNS - 1) begin : g_right_edge
			assign right_bits = '0;
		end else begin : g_right
			assign right_bits = bits[j+1];
		end

		mgfs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.accept     (accept),
			.last       (in_data.last_row),
			.active     (COLS_W'(j) < columns_q),
			.fire_in    (in_data.fire_row[j]),
			.obst_in    (in_data.obstacle_row[j]),
			.left_bits  (left_bits),
			.right_bits (right_bits),
			.own_bits   (bits[j]),
			.res_held   (res_held[j]),
			.res_last   (res_last[j])
		);
	end

	// Columns beyond the grid read as zero
	assign row_held = ROW_W'(res_held);
	assign row_last = ROW_W'(res_last);

	// Results of the taken row: held row first, then the last row
	always_comb begin
		push_second = '{new_fire_row: row_last, final_row: 1'b1};
		if (held_q) begin
			push_first = '{new_fire_row: row_held, final_row: 1'b0};
		end else begin
			push_first = push_second;
		end
		if (accept) begin
			push_n = PUSH_W'(held_q) + PUSH_W'(in_data.last_row);
		end else begin
			push_n = '0;
		end
	end

	mgfs_out_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_n      (push_n),
		.push_first  (push_first),
		.push_second (push_second),
		.room        (room),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

// ===== src/mgfs_cell.sv =====
// ----------------------------------------------------------------------------
// mgfs_cell - one grid column
// Holds the column's bits of the two stored fire rows and the stored
// obstacle row, shows them to both neighbors and forms the column's bits
// of the held-row and last-row results.
// ----------------------------------------------------------------------------
module mgfs_cell
	import mgfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,     // input item taken this cycle
	input  logic       last,       // taken item closes the grid
	input  logic       active,     // column is in use
	input  logic       fire_in,
	input  logic       obst_in,
	input  cell_bits_t left_bits,
	input  cell_bits_t right_bits,
	output cell_bits_t own_bits,
	output logic       res_held,   // new fire of the held row
	output logic       res_last    // new fire of the arriving last row
);

	logic two_q;
	logic prev_q;
	logic obst_q;
	logic cur;
	logic obst_cur;
	logic near_held;
	logic near_last;

	// Masked arriving bits
	assign cur      = fire_in & active;
	assign obst_cur = obst_in & active;

	assign own_bits = '{two: two_q, prev: prev_q, cur: cur};

	// 3x3 neighborhood of the held row: above, itself, arriving row below
	assign near_held = left_bits.two  | two_q  | right_bits.two  |
	                   left_bits.prev | prev_q | right_bits.prev |
	                   left_bits.cur  | cur    | right_bits.cur;

	// Neighborhood of the last row: nothing below it
	assign near_last = left_bits.prev | prev_q | right_bits.prev |
	                   left_bits.cur  | cur    | right_bits.cur;

	assign res_held = (prev_q | (near_held & ~obst_q)) & active;
	assign res_last = (cur | (near_last & ~obst_cur)) & active;

	// Row shift; the last row of a grid clears the column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_q  <= 1'b0;
			prev_q <= 1'b0;
			obst_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				two_q  <= 1'b0;
				prev_q <= 1'b0;
				obst_q <= 1'b0;
			end else begin
				two_q  <= prev_q;
				prev_q <= cur;
				obst_q <= obst_cur;
			end
		end
	end

endmodule

// ===== src/mgfs_out_queue.sv =====
// ----------------------------------------------------------------------------
// mgfs_out_queue - result queue
// Shift queue of result items; takes up to two results per cycle and
// shows the oldest one at the head. Accepts input work while it has room
// for two more results.
// ----------------------------------------------------------------------------
module mgfs_out_queue
	import mgfs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [PUSH_W-1:0] push_n,      // results written this cycle
	input  out_item_t         push_first,
	input  out_item_t         push_second,
	output logic              room,        // space for two results
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data
);

	out_item_t         entry_q [QUEUE_DEPTH];
	out_item_t         entry_next [QUEUE_DEPTH];
	logic [QCNT_W-1:0] count_q;
	logic              pop;
	logic [QCNT_W-1:0] wpos;
	logic [QCNT_W-1:0] wpos_p1;

	assign out_valid = (count_q != '0);
	assign out_data  = entry_q[0];
	assign pop       = out_valid & out_ready;
	assign room      = (count_q < QCNT_W'(QUEUE_DEPTH - 1));

	assign wpos    = count_q - QCNT_W'(pop);
	assign wpos_p1 = wpos + QCNT_W'(1);

	// Shift on pop, then drop new results behind the remaining ones
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (pop && (i < QUEUE_DEPTH - 1)) begin
				entry_next[i] = entry_q[(i + 1) % QUEUE_DEPTH];
			end else begin
				entry_next[i] = entry_q[i];
			end
			if ((push_n != '0) && (QCNT_W'(i) == wpos)) begin
				entry_next[i] = push_first;
			end else if ((push_n == PUSH_W'(2)) && (QCNT_W'(i) == wpos_p1)) begin
				entry_next[i] = push_second;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			entry_q[i] <= entry_next[i];
		end
	end

	// Fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q - QCNT_W'(pop) + QCNT_W'(push_n);
		end
	end

endmodule

// ===== src/mgfs_checker.sv =====
// ----------------------------------------------------------------------------
// mgfs_checker - port-level checks of the fire spread block
// Watches the channels of the top level; attached by the bind below.
// ----------------------------------------------------------------------------
module mgfs_checker
	import mgfs_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// A stalled result stays offered
	a_out_hold : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_out_stable : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	// A taken last row always yields a result in the next cycle
	a_last_result : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last_row |=> out_valid)
		else $error("last row gave no result");

	// Input is held off only while results are waiting
	a_backpressure : assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

endmodule

bind masked_grid_fire_spread mgfs_checker u_mgfs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - testbench of masked_grid_fire_spread
// Streams grids of fire and obstacle rows through the block. A row-by-row
// spread predictor keeps its own copy of the held rows and the column count,
// and each new row that comes out is checked against the oldest prediction.
// Phases vary the column count, sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import mgfs_pkg::*;

	localparam int QUIET_LIMIT = 2000;      // cycles with no item moving
	localparam int OUT_HOLD_CYCLES = 150;   // long receiver hold-off
	localparam int SETTLE_CYCLES = 4;       // block latency plus margin

	logic              clk;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	in_item_t          in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_item_t         out_data;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [COLS_W-1:0] cfg_data = '0;

	masked_grid_fire_spread u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// rows waiting to be sent, new rows waiting to come out
	in_item_t  rows_pending[$];
	out_item_t new_rows_due[$];

	// predictor state
	logic [COLS_W-1:0] cols_setting = COLS_RESET;
	logic [ROW_W-1:0]  fire_above = '0;
	logic [ROW_W-1:0]  fire_held = '0;
	logic [ROW_W-1:0]  obst_held = '0;
	logic [1:0]        rows_held = '0;

	// handshake flags seen at the last rising edge
	bit row_taken = 1'b0;
	bit cols_taken = 1'b0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit out_hold_req = 1'b0;
	int out_hold_left = 0;
	int quiet_cycles = 0;
	int grid_rows_left = 0;

	int rows_queued = 0;
	int grids_started = 0;
	int rows_checked = 0;
	int cols_writes = 0;
	int errors = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// bits at column positions at or above the count are inactive
	function automatic logic [ROW_W-1:0] active_cols(logic [COLS_W-1:0] n);
		if (n >= ROW_W)
			return '1;
		return (64'd1 << n) - 64'd1;
	endfunction

	function automatic logic [ROW_W-1:0] smear(logic [ROW_W-1:0] x);
		return x | (x << 1) | (x >> 1);
	endfunction

	function automatic logic [ROW_W-1:0] burn_row(logic [ROW_W-1:0] above,
		logic [ROW_W-1:0] self, logic [ROW_W-1:0] below,
		logic [ROW_W-1:0] obst, logic [ROW_W-1:0] mask);
		logic [ROW_W-1:0] near;
		near = smear(above) | smear(self) | smear(below);
		return (self | (near & ~obst)) & mask;
	endfunction

	// one accepted row: emit the held row, and on a last row the row itself
	task automatic spread_one_row(in_item_t row);
		logic [ROW_W-1:0] mask;
		logic [ROW_W-1:0] fire;
		logic [ROW_W-1:0] obst;
		out_item_t        res;
		mask = active_cols(cols_setting);
		fire = row.fire_row & mask;
		obst = row.obstacle_row & mask;
		if (rows_held != 0) begin
			res.new_fire_row = burn_row(fire_above, fire_held, fire, obst_held, mask);
			res.final_row = 1'b0;
			new_rows_due.push_back(res);
		end
		if (row.last_row) begin
			res.new_fire_row = burn_row(fire_held, fire, '0, obst, mask);
			res.final_row = 1'b1;
			new_rows_due.push_back(res);
			fire_above = '0;
			fire_held = '0;
			obst_held = '0;
			rows_held = '0;
		end else begin
			fire_above = fire_held;
			fire_held = fire;
			obst_held = obst;
			if (rows_held < 2)
				rows_held++;
		end
	endtask

	// monitor: predict on taken rows, check new rows, watch for a hang
	always @(posedge clk) begin
		out_item_t want;
		row_taken = arst_n && in_valid && in_ready;
		cols_taken = arst_n && cfg_valid && cfg_ready;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (new_rows_due.size() == 0) begin
				$display("%0t: new row with none expected: %h final %b", $time,
					out_data.new_fire_row, out_data.final_row);
				errors++;
			end else begin
				want = new_rows_due.pop_front();
				if (out_data.new_fire_row !== want.new_fire_row) begin
					$display("%0t: new_fire_row expected %h actual %h", $time,
						want.new_fire_row, out_data.new_fire_row);
					errors++;
				end
				if (out_data.final_row !== want.final_row) begin
					$display("%0t: final_row expected %b actual %b", $time,
						want.final_row, out_data.final_row);
					errors++;
				end
				rows_checked++;
			end
		end
		if (row_taken)
			spread_one_row(in_data);
		if (cols_taken)
			cols_setting = cfg_data;
		if (!arst_n || row_taken || cols_taken || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	// row driver: hold an offered row until taken, else maybe offer the next
	always @(negedge clk) begin : drive_rows
		logic     offer;
		in_item_t next_row;
		offer = in_valid && !row_taken;
		next_row = in_data;
		if (!offer && arst_n && rows_pending.size() != 0
				&& $urandom_range(99) >= send_idle_pct) begin
			offer = 1'b1;
			next_row = rows_pending.pop_front();
		end
		in_valid <= offer;
		in_data <= next_row;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_hold_req) begin
				out_hold_left = OUT_HOLD_CYCLES;
				out_hold_req = 1'b0;
			end
			if (out_hold_left > 0) begin
				out_hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic push_row(logic [ROW_W-1:0] fire, logic [ROW_W-1:0] obst, logic last);
		in_item_t row;
		row.fire_row = fire;
		row.obstacle_row = obst;
		row.last_row = last;
		rows_pending.push_back(row);
		rows_queued++;
	endtask

	function automatic logic [ROW_W-1:0] random_row();
		logic [ROW_W-1:0] r;
		case ($urandom_range(9))
			0: r = '0;
			1: r = '1;
			2, 3, 4: begin
				r = '0;
				repeat ($urandom_range(1, 3))
					r[$urandom_range(ROW_W - 1)] = 1'b1;
			end
			5, 6: r = {$urandom, $urandom} & {$urandom, $urandom};
			default: r = {$urandom, $urandom};
		endcase
		return r;
	endfunction

	// stream of grids; a grid may run on across phase boundaries
	task automatic queue_rows(int n);
		int pick;
		repeat (n) begin
			if (grid_rows_left == 0) begin
				pick = $urandom_range(99);
				if (pick < 10)
					grid_rows_left = 1;
				else if (pick < 20)
					grid_rows_left = 2;
				else if (pick < 95)
					grid_rows_left = $urandom_range(3, 12);
				else
					grid_rows_left = $urandom_range(20, 60);
				grids_started++;
			end
			grid_rows_left--;
			push_row(random_row(), random_row(), grid_rows_left == 0);
		end
	endtask

	// sender pause: wait until every row is sent and every new row is back;
	// looked at just after the falling edge so the driver's update is seen
	task automatic wait_idle();
		do begin
			@(negedge clk);
			#1;
		end while (rows_pending.size() != 0 || in_valid || new_rows_due.size() != 0);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_cols(logic [COLS_W-1:0] n);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= n;
		do
			@(negedge clk);
		while (!cols_taken);
		cfg_valid <= 1'b0;
		cols_writes++;
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, int n_rows,
		logic [COLS_W-1:0] cols);
		wait_idle();
		write_cols(cols);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		queue_rows(n_rows / 2);
		wait_idle();
		queue_rows(n_rows - n_rows / 2);
	endtask

	initial begin
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: single-row grids at full width
		push_row('1, '0, 1'b1);
		push_row('0, '0, 1'b1);
		// edge columns, burning obstacle cell, fully blocked row
		push_row(64'd1, '0, 1'b0);
		push_row(64'd1 << 63, '1, 1'b0);
		push_row('0, '1, 1'b1);
		// two-row grid, everything burning under obstacles
		push_row('1, '1, 1'b0);
		push_row('0, '0, 1'b1);
		// alternating fire bits against the opposite obstacle bits
		push_row('0, '0, 1'b0);
		push_row({32{2'b10}}, {32{2'b01}}, 1'b0);
		push_row('0, '0, 1'b1);
		wait_idle();

		// no active column: every new row is zero
		write_cols(7'd0);
		push_row('1, '0, 1'b0);
		push_row('1, '1, 1'b1);
		wait_idle();

		// count above the grid width acts as full width
		write_cols(7'd127);
		push_row((64'd1 << 63) | 64'd1, '0, 1'b1);
		wait_idle();

		write_cols(7'd1);
		push_row('1, '0, 1'b0);
		push_row('1, '0, 1'b1);
		wait_idle();

		// count changed while a row is held
		write_cols(7'd63);
		push_row(64'd1 << 62, '0, 1'b0);
		wait_idle();
		write_cols(7'd64);
		push_row('0, '0, 1'b0);
		push_row(64'd1 << 63, '0, 1'b1);
		wait_idle();

		// random phases
		run_phase(0, 0, 450, 7'd64);
		run_phase(66, 0, 450, 7'($urandom_range(2, 63)));
		run_phase(0, 66, 450, 7'd64);
		run_phase(34, 34, 450, 7'($urandom_range(1, 64)));

		// receiver holds off while rows keep coming, so the block backs up
		wait_idle();
		write_cols(7'd64);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		out_hold_req = 1'b1;
		queue_rows(60);
		wait_idle();

		repeat (SETTLE_CYCLES * 2)
			@(negedge clk);
		if (new_rows_due.size() != 0) begin
			$display("%0t: %0d new rows never came out", $time, new_rows_due.size());
			errors++;
		end
		$display("tb_top: %0d rows in about %0d grids, %0d new rows checked",
			rows_queued, grids_started, rows_checked);
		$display("tb_top: %0d column count writes, %0d mismatches", cols_writes, errors);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
